@@ src/cpc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpc_pkg
// shared types, constants and helpers of the coppock curve filter
// ----------------------------------------------------------------------------
package cpc_pkg;

   // csr register indexes
   localparam logic [1:0] CSR_WMA_LENGTH        = 2'd0;
   localparam logic [1:0] CSR_LONG_RATE_PERIOD  = 2'd1;
   localparam logic [1:0] CSR_SHORT_RATE_PERIOD = 2'd2;

   // csr reset values
   localparam logic [6:0] WMA_LENGTH_RESET        = 7'd10;
   localparam logic [6:0] LONG_RATE_PERIOD_RESET  = 7'd14;
   localparam logic [6:0] SHORT_RATE_PERIOD_RESET = 7'd11;

   // 100 percent in q16.16
   localparam logic [22:0] PCT_SCALE = 23'd6553600;

   // one quotient bit per step
   localparam int DIV_STEPS = 64;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               clip;
   } sat_type;

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      r.clip  = 1'b0;
      r.value = v[31:0];
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r.value = 32'sh7FFF_FFFF;
         r.clip  = 1'b1;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r.value = -32'sh8000_0000;
         r.clip  = 1'b1;
      end
      return r;
   endfunction

endpackage

@@ src/cpc_divider.sv @@
// ----------------------------------------------------------------------------
// cpc_divider
// signed 64 by 32 bit restoring divider, one quotient bit per cycle,
// quotient truncated toward zero
// ----------------------------------------------------------------------------
module cpc_divider
   import cpc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  dividend,
   input  logic signed [31:0]  divisor,
   output div_status_type      status,
   output logic signed [63:0]  quotient
);

   localparam int CW = $clog2(DIV_STEPS);

   logic [63:0]   dvd_ff, dvd_in;
   logic [31:0]   dsr_ff, dsr_in;
   logic [31:0]   rem_ff, rem_in;
   logic          neg_ff, neg_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [32:0]   trial;

   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[63]};
      if (start) begin
         dvd_in  = dividend[63] ? 64'(-dividend) : 64'(dividend);
         dsr_in  = divisor[31] ? 32'(-divisor) : 32'(divisor);
         neg_in  = dividend[63] ^ divisor[31];
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = 32'(trial - {1'b0, dsr_ff});
            dvd_in = {dvd_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            dvd_in = {dvd_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = neg_ff ? -$signed(dvd_ff) : $signed(dvd_ff);

endmodule

@@ src/coppock_curve_filter.sv @@
// ----------------------------------------------------------------------------
// coppock_curve_filter
// coppock curve over a stream of q24.8 closing prices, q16.16 output
// ----------------------------------------------------------------------------
// One closing price per transfer in, one coppock value per transfer out. The
// long and short rates of change are each 100*(c-prev)/prev in q16.16, and
// their saturated sum goes into a ring; the output is the linearly weighted
// mean of the last n = min(wma_length, bars) sums, newest weighted heaviest.
// All three divisions run one after another on a single shared 64-step
// restoring divider, and the window is walked one ring entry per cycle
// through a registered multiply and accumulate. An item is quickest when
// both rates are short of history or zero and slowest when both rate
// divisions are needed; req_stall is high for the whole of an item.
// A finished result waits in the output register, so the next price can
// be taken while it is still stalled. Setting req_restart clears the
// history before the bar is taken. csr writes are taken at any time but are
// meant for while the block is idle; csr_ready is always high.
// ----------------------------------------------------------------------------
module coppock_curve_filter
   import cpc_pkg::*;
#(
   parameter int MAX_RATE_PERIOD = 64,
   parameter int MAX_WMA_LENGTH  = 64
) (
   input  logic               clock,
   input  logic               reset,
   // price input
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_close_price,
   input  logic               req_restart,
   // result output
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_curve_value,
   output logic               rsp_saturated,
   // register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [6:0]         csr_data
);

   localparam int PW       = $clog2(MAX_RATE_PERIOD);
   localparam int SW       = $clog2(MAX_WMA_LENGTH);
   localparam int RLW      = $clog2(MAX_RATE_PERIOD + 1);
   localparam int KW       = $clog2(MAX_WMA_LENGTH + 1);
   localparam int TW       = 2 * KW;
   localparam int BARS_CAP = ((MAX_RATE_PERIOD > MAX_WMA_LENGTH) ?
                              MAX_RATE_PERIOD : MAX_WMA_LENGTH) + 1;
   localparam int BW       = $clog2(BARS_CAP + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_LADDR, S_LCHK, S_LDIV, S_SADDR, S_SCHK, S_SDIV,
      S_STORE, S_WALK, S_FDIV, S_DONE
   } state_type;

   // clamp a period to 1 .. max
   function automatic logic [RLW-1:0] clamp_rate(input logic [6:0] v);
      logic [RLW-1:0] r;
      r = RLW'(v);
      if (v == 7'd0) r = RLW'(1);
      else if (32'(v) > 32'(MAX_RATE_PERIOD)) r = RLW'(MAX_RATE_PERIOD);
      return r;
   endfunction

   function automatic logic [KW-1:0] clamp_wma(input logic [6:0] v);
      logic [KW-1:0] r;
      r = KW'(v);
      if (v == 7'd0) r = KW'(1);
      else if (32'(v) > 32'(MAX_WMA_LENGTH)) r = KW'(MAX_WMA_LENGTH);
      return r;
   endfunction

   // slot p bars back from the next write slot
   function automatic logic [PW-1:0] back_slot(input logic [PW-1:0] ptr,
                                                input logic [RLW-1:0] p);
      logic [PW:0] s;
      s = (PW+1)'(ptr) + (PW+1)'(MAX_RATE_PERIOD) - (PW+1)'(p);
      if (s >= (PW+1)'(MAX_RATE_PERIOD)) s = s - (PW+1)'(MAX_RATE_PERIOD);
      return s[PW-1:0];
   endfunction

   // memories
   logic signed [31:0] price_mem [MAX_RATE_PERIOD];
   logic signed [31:0] sum_mem   [MAX_WMA_LENGTH];
   logic signed [31:0] price_rd_ff;
   logic signed [31:0] sum_rd_ff;
   logic [PW-1:0]      price_raddr;
   logic signed [31:0] sum_wdata;

   // control and datapath registers
   state_type          state_ff, state_in;
   logic [6:0]         wma_len_ff, wma_len_in;
   logic [6:0]         long_per_ff, long_per_in;
   logic [6:0]         short_per_ff, short_per_in;
   logic [BW-1:0]      bars_ff, bars_in;
   logic [PW-1:0]      ptr_ff, ptr_in;
   logic [SW-1:0]      sptr_ff, sptr_in;
   logic signed [31:0] close_ff, close_in;
   logic signed [31:0] rate_long_ff, rate_long_in;
   logic signed [31:0] rate_short_ff, rate_short_in;
   logic               clip_ff, clip_in;
   logic [KW-1:0]      n_ff, n_in;
   logic [TW-1:0]      wtot_ff, wtot_in;
   logic [SW-1:0]      walk_slot_ff, walk_slot_in;
   logic [KW-1:0]      issue_k_ff, issue_k_in;
   logic               issue_done_ff, issue_done_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [KW-1:0]      rd_k_ff, rd_k_in;
   logic               prod_vld_ff, prod_vld_in;
   logic signed [32+KW:0] prod_ff, prod_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] result_ff, result_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic               rsp_sat_ff, rsp_sat_in;

   // comb helpers
   logic [RLW-1:0]     p_long, p_short, p_cur;
   logic [KW-1:0]      w_len;
   logic signed [32:0] diff;
   logic signed [56:0] num;
   logic [BW-1:0]      bars_next;
   logic [SW:0]        start_slot;
   logic [SW:0]        slot_inc;
   sat_type            q_sat;
   sat_type            sum_sat;

   // shared divider
   logic               div_start;
   logic signed [63:0] div_dividend;
   logic signed [31:0] div_divisor;
   div_status_type     div_status;
   logic signed [63:0] div_quotient;

   cpc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign p_long  = clamp_rate(long_per_ff);
   assign p_short = clamp_rate(short_per_ff);
   assign w_len   = clamp_wma(wma_len_ff);
   assign q_sat   = sat32(div_quotient);
   assign sum_sat = sat32(64'(rate_long_ff) + 64'(rate_short_ff));
   assign sum_wdata = sum_sat.value;

   always_comb begin
      state_in      = state_ff;
      wma_len_in    = wma_len_ff;
      long_per_in   = long_per_ff;
      short_per_in  = short_per_ff;
      bars_in       = bars_ff;
      ptr_in        = ptr_ff;
      sptr_in       = sptr_ff;
      close_in      = close_ff;
      rate_long_in  = rate_long_ff;
      rate_short_in = rate_short_ff;
      clip_in       = clip_ff;
      n_in          = n_ff;
      wtot_in       = wtot_ff;
      walk_slot_in  = walk_slot_ff;
      issue_k_in    = issue_k_ff;
      issue_done_in = issue_done_ff;
      rd_vld_in     = 1'b0;
      rd_k_in       = rd_k_ff;
      prod_vld_in   = 1'b0;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_sat_in    = rsp_sat_ff;
      div_start     = 1'b0;
      div_dividend  = acc_ff;
      div_divisor   = {{(32-TW){1'b0}}, wtot_ff};
      p_cur         = (state_ff == S_LADDR || state_ff == S_LCHK) ? p_long : p_short;
      price_raddr   = back_slot(ptr_ff, p_cur);
      diff          = 33'(close_ff) - 33'(price_rd_ff);
      num           = diff * $signed({1'b0, PCT_SCALE});
      bars_next     = (32'(bars_ff) < 32'(BARS_CAP)) ? bars_ff + 1'b1 : bars_ff;
      start_slot    = '0;
      slot_inc      = (SW+1)'(walk_slot_ff) + 1'b1;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_WMA_LENGTH:        wma_len_in   = csr_data;
            CSR_LONG_RATE_PERIOD:  long_per_in  = csr_data;
            CSR_SHORT_RATE_PERIOD: short_per_in = csr_data;
            default: ;
         endcase
      end

      // output register drains independently of the sequencer
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               close_in = req_close_price;
               clip_in  = 1'b0;
               if (req_restart) begin
                  bars_in = '0;
                  ptr_in  = '0;
                  sptr_in = '0;
               end
               state_in = S_LADDR;
            end
         end
         S_LADDR: state_in = S_LCHK;
         S_LCHK: begin
            rate_long_in = '0;
            if (32'(bars_ff) < 32'(p_long) || price_rd_ff == 32'sd0) begin
               state_in = S_SADDR;
            end else begin
               div_start    = 1'b1;
               div_dividend = 64'(num);
               div_divisor  = price_rd_ff;
               state_in     = S_LDIV;
            end
         end
         S_LDIV: begin
            if (div_status.done) begin
               rate_long_in = q_sat.value;
               clip_in      = clip_ff | q_sat.clip;
               state_in     = S_SADDR;
            end
         end
         S_SADDR: state_in = S_SCHK;
         S_SCHK: begin
            rate_short_in = '0;
            if (32'(bars_ff) < 32'(p_short) || price_rd_ff == 32'sd0) begin
               state_in = S_STORE;
            end else begin
               div_start    = 1'b1;
               div_dividend = 64'(num);
               div_divisor  = price_rd_ff;
               state_in     = S_SDIV;
            end
         end
         S_SDIV: begin
            if (div_status.done) begin
               rate_short_in = q_sat.value;
               clip_in       = clip_ff | q_sat.clip;
               state_in      = S_STORE;
            end
         end
         S_STORE: begin
            // rings are written by their own clocked blocks in this state
            clip_in = clip_ff | sum_sat.clip;
            ptr_in  = (32'(ptr_ff) == MAX_RATE_PERIOD - 1) ? '0 : ptr_ff + 1'b1;
            sptr_in = (32'(sptr_ff) == MAX_WMA_LENGTH - 1) ? '0 : sptr_ff + 1'b1;
            bars_in = bars_next;
            n_in    = (32'(w_len) < 32'(bars_next)) ? w_len : KW'(bars_next);
            wtot_in = TW'((TW'(n_in) * (TW'(n_in) + 1'b1)) >> 1);
            // oldest window entry: n back from the new write slot
            start_slot = (SW+1)'(sptr_in) + (SW+1)'(MAX_WMA_LENGTH) - (SW+1)'(n_in);
            if (start_slot >= (SW+1)'(MAX_WMA_LENGTH))
               start_slot = start_slot - (SW+1)'(MAX_WMA_LENGTH);
            walk_slot_in  = start_slot[SW-1:0];
            issue_k_in    = KW'(1);
            issue_done_in = 1'b0;
            acc_in        = '0;
            state_in      = S_WALK;
         end
         S_WALK: begin
            // issue one window read per cycle
            if (!issue_done_ff) begin
               rd_vld_in    = 1'b1;
               rd_k_in      = issue_k_ff;
               walk_slot_in = (slot_inc == (SW+1)'(MAX_WMA_LENGTH)) ? '0 : slot_inc[SW-1:0];
               if (issue_k_ff == n_ff) issue_done_in = 1'b1;
               else issue_k_in = issue_k_ff + 1'b1;
            end
            // weight the read data
            if (rd_vld_ff) begin
               prod_vld_in = 1'b1;
               prod_in     = sum_rd_ff * $signed({1'b0, rd_k_ff});
            end
            // accumulate
            if (prod_vld_ff) acc_in = acc_ff + 64'(prod_ff);
            if (issue_done_ff && !rd_vld_ff && !prod_vld_ff) begin
               div_start = 1'b1;
               state_in  = S_FDIV;
            end
         end
         S_FDIV: begin
            if (div_status.done) begin
               result_in = q_sat.value;
               clip_in   = clip_ff | q_sat.clip;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
               rsp_sat_in   = clip_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wma_len_ff    <= WMA_LENGTH_RESET;
         long_per_ff   <= LONG_RATE_PERIOD_RESET;
         short_per_ff  <= SHORT_RATE_PERIOD_RESET;
         bars_ff       <= '0;
         ptr_ff        <= '0;
         sptr_ff       <= '0;
         issue_done_ff <= 1'b1;
         rd_vld_ff     <= 1'b0;
         prod_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wma_len_ff    <= wma_len_in;
         long_per_ff   <= long_per_in;
         short_per_ff  <= short_per_in;
         bars_ff       <= bars_in;
         ptr_ff        <= ptr_in;
         sptr_ff       <= sptr_in;
         issue_done_ff <= issue_done_in;
         rd_vld_ff     <= rd_vld_in;
         prod_vld_ff   <= prod_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      close_ff      <= close_in;
      rate_long_ff  <= rate_long_in;
      rate_short_ff <= rate_short_in;
      clip_ff       <= clip_in;
      n_ff          <= n_in;
      wtot_ff       <= wtot_in;
      walk_slot_ff  <= walk_slot_in;
      issue_k_ff    <= issue_k_in;
      rd_k_ff       <= rd_k_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      result_ff     <= result_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   // price history
   always_ff @(posedge clock) begin
      if (state_ff == S_STORE) price_mem[ptr_ff] <= close_ff;
      price_rd_ff <= price_mem[price_raddr];
   end

   // rate sum history
   always_ff @(posedge clock) begin
      if (state_ff == S_STORE) sum_mem[sptr_ff] <= sum_wdata;
      sum_rd_ff <= sum_mem[walk_slot_ff];
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_curve_value = rsp_value_ff;
   assign rsp_saturated   = rsp_sat_ff;
   assign csr_ready       = 1'b1;

   // divider is never restarted while a division is in flight
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   // bar count stays at or below its cap
   a_bars_capped: assert property (@(posedge clock) disable iff (reset)
      32'(bars_ff) <= BARS_CAP)
      else $error("bar count beyond cap");

   // window walk never issues past the window length
   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && !issue_done_ff) |-> (issue_k_ff <= n_ff))
      else $error("window walk overran");

   // a result is only loaded when the sequencer finishes an item
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result without finished item");

endmodule
